/* hw/rtl/sse_pkg.sv */
// shared types, codes and constants of the stereo spatial effect core
// no dependencies

package sse_pkg;

    localparam int SMP_W       = 16;
    localparam int POS_W       = 12;
    localparam int AMT_W       = 9;
    localparam int MODE_W      = 3;
    localparam int ADDR_X_W    = 13;
    localparam int PROD_W      = 40;
    localparam int XF_GAIN_W   = 23;
    localparam int RM_GAIN_W   = 22;
    localparam int RM_OFS_W    = 11;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;
    localparam int SH_W        = 5;

    localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HEADPHONE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPK_A     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SPK_B     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SPK_C     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CUSTOM    = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HP_EN  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_XF_STR = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROOM   = 2'd3;

    localparam logic [AMT_W-1:0] AMT_MAX   = 9'd256;
    localparam logic [AMT_W-1:0] AMT_RESET = 9'd128;

    localparam logic [14:0] XF_COEF     = 15'd19661;
    localparam logic [13:0] RM_COEF     = 14'd13107;
    localparam logic [12:0] EMP_COEF    = 13'd6554;
    localparam logic [14:0] ST_COEF     = 15'd22938;
    localparam logic [10:0] RM_OFS_COEF = 11'd2000;
    localparam int          RM_OFS_SH   = 8;

    localparam logic [SH_W-1:0] SH_16 = 5'd16;
    localparam logic [SH_W-1:0] SH_24 = 5'd24;
    localparam logic [SH_W-1:0] SH_25 = 5'd25;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic load;
        logic clear;
        logic xf_rd;
        logic xf_mul;
        logic xf_add;
        logic xf_half;
        logic emp_mul;
        logic emp_add;
        logic rm_rd;
        logic rm_mul;
        logic rm_add;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_stat;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hp_en;
        logic              xf_on;
        logic              rm_on;
    } t_cfg;

    // round half up, then drop k bits
    function automatic t_prod rnd(input t_prod v, input logic [SH_W-1:0] k);
        t_prod half;
        half = t_prod'(1) <<< (k - 5'd1);
        return (v + half) >>> k;
    endfunction

    function automatic t_smp sat16(input t_prod v);
        if (v > t_prod'(32767)) begin
            return 16'sh7fff;
        end else if (v < -t_prod'(32768)) begin
            return 16'sh8000;
        end
        return v[SMP_W-1:0];
    endfunction

    function automatic logic [AMT_W-1:0] clamp_amt(input logic [AMT_W-1:0] v);
        return (v > AMT_MAX) ? AMT_MAX : v;
    endfunction

endpackage

/* hw/rtl/stereo_spatial_effect_core.sv */
// stereo spatial effect core: config registers, gain precompute, output register
// depends on sse_pkg, sse_ctrl, sse_dpath
//
// channel    dir   handshake               contents
// s_axis     in    tvalid/tready           tdata: left_in[15:0] right_in[31:16] position[43:32]
// m_axis     out   tvalid/tready           tdata: left_out[15:0] right_out[31:16]
// apb        in    psel/penable/pready     mode, headphone enable, crossfeed, room
//
// each word passes load and output states; crossfeed adds read, multiply and add, emphasis
// multiply and add; room address states unless after crossfeed, then read, multiply and add
// after reset a clearing pass over the reflection store holds s_axis_tready low
// one finished word waits in the output register while the next word is accepted

module stereo_spatial_effect_core #(
    parameter int CROSSFEED_DEPTH  = 64,
    parameter int REFLECTION_DEPTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sse_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // left_in, right_in, position
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sse_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // left_out, right_out
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sse_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sse_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sse_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import sse_pkg::*;

    logic [MODE_W-1:0]    r_mode;
    logic                 r_hp_en;
    logic [AMT_W-1:0]     r_xf_str;
    logic [AMT_W-1:0]     r_room;
    logic [XF_GAIN_W-1:0] r_xf_gain;
    logic [RM_GAIN_W-1:0] r_rm_gain;
    logic [RM_OFS_W-1:0]  r_rm_ofs;
    logic                 r_out_valid;
    t_smp                 r_out_l;
    t_smp                 r_out_r;

    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic [AMT_W-1:0]     w_xf_cl;
    logic [AMT_W-1:0]     w_rm_cl;
    logic [18:0]          w_ofs_full;
    logic                 w_out_free;
    t_cfg                 w_cfg;
    t_cmd                 w_cmd;
    t_stat                w_stat;
    t_smp                 w_dp_l;
    t_smp                 w_dp_r;

    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign w_reg_idx     = paddr[CFG_ADDR_W-1:2];
    assign w_xf_cl       = clamp_amt(r_xf_str);
    assign w_rm_cl       = clamp_amt(r_room);
    assign w_ofs_full    = 19'(w_rm_cl) * 19'(RM_OFS_COEF);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_l};

    assign w_cfg.mode  = r_mode;
    assign w_cfg.hp_en = r_hp_en;
    assign w_cfg.xf_on = (r_xf_str != '0);
    assign w_cfg.rm_on = (r_room != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NONE;
            r_hp_en  <= 1'b0;
            r_xf_str <= AMT_RESET;
            r_room   <= AMT_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                REG_HP_EN:  r_hp_en  <= pwdata[0];
                REG_XF_STR: r_xf_str <= pwdata[AMT_W-1:0];
                REG_ROOM:   r_room   <= pwdata[AMT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_MODE:   prdata = CFG_DATA_W'(r_mode);
            REG_HP_EN:  prdata = CFG_DATA_W'(r_hp_en);
            REG_XF_STR: prdata = CFG_DATA_W'(r_xf_str);
            REG_ROOM:   prdata = CFG_DATA_W'(r_room);
            default:    prdata = '0;
        endcase
    end

    // gains and reflection offset follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_xf_gain <= XF_GAIN_W'(w_xf_cl) * XF_GAIN_W'(XF_COEF);
        r_rm_gain <= RM_GAIN_W'(w_rm_cl) * RM_GAIN_W'(RM_COEF);
        r_rm_ofs  <= RM_OFS_W'(w_ofs_full >> RM_OFS_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_l <= w_dp_l;
            r_out_r <= w_dp_r;
        end
    end

    sse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sse_dpath #(
        .XF_DEPTH (CROSSFEED_DEPTH),
        .RF_DEPTH (REFLECTION_DEPTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_left    (s_axis_tdata[SMP_W-1:0]),
        .i_right   (s_axis_tdata[2*SMP_W-1:SMP_W]),
        .i_pos     (s_axis_tdata[2*SMP_W+POS_W-1:2*SMP_W]),
        .i_xf_gain (r_xf_gain),
        .i_rm_gain (r_rm_gain),
        .i_rm_ofs  (r_rm_ofs),
        .o_left    (w_dp_l),
        .o_right   (w_dp_r)
    );

endmodule

/* hw/rtl/sse_amod.sv */
// constant-modulus reduction of a small address, two registered stages
// multiply by a rounded-up reciprocal, then subtract quotient times depth; uses sse_pkg

module sse_amod #(
    parameter int DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic [sse_pkg::ADDR_X_W-1:0]     i_x,
    output logic [$clog2(DEPTH)-1:0]         o_rem
);
    import sse_pkg::*;

    localparam int L_W = $clog2(DEPTH);
    localparam int SH  = ADDR_X_W + L_W;
    localparam int M_W = ADDR_X_W + 2;
    localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam int P_W = ADDR_X_W + M_W;
    localparam int D_W = L_W + 1;
    localparam int Q_W = ADDR_X_W;
    localparam int R_W = Q_W + D_W;

    logic [P_W-1:0]      w_prod;
    logic [Q_W-1:0]      r_q;
    logic [ADDR_X_W-1:0] r_x;
    logic [R_W-1:0]      w_qd;
    logic [R_W-1:0]      w_rem;
    logic [L_W-1:0]      r_rem;

    assign w_prod = P_W'(i_x) * P_W'(M_W'(RECIP));
    assign w_qd   = R_W'(r_q) * R_W'(D_W'(DEPTH));
    assign w_rem  = R_W'(r_x) - w_qd;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        r_q   <= Q_W'(w_prod >> SH);
        r_x   <= i_x;
        r_rem <= w_rem[L_W-1:0];
    end

endmodule

/* hw/rtl/sse_ctrl.sv */
// sequencer of the effect core: one-hot state machine issuing datapath commands
// uses sse_pkg command, status and config structs

module sse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sse_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_free,
    input  sse_pkg::t_stat i_stat,
    output sse_pkg::t_cmd  o_cmd
);
    import sse_pkg::*;

    typedef enum logic [12:0] {
        ST_CLEAR   = 13'b0000000000001,
        ST_IDLE    = 13'b0000000000010,
        ST_AGEN0   = 13'b0000000000100,
        ST_AGEN1   = 13'b0000000001000,
        ST_XF_RD   = 13'b0000000010000,
        ST_XF_MUL  = 13'b0000000100000,
        ST_XF_ADD  = 13'b0000001000000,
        ST_EMP_MUL = 13'b0000010000000,
        ST_EMP_ADD = 13'b0000100000000,
        ST_RM_RD   = 13'b0001000000000,
        ST_RM_MUL  = 13'b0010000000000,
        ST_RM_ADD  = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.xf_half = (i_cfg.mode == MODE_CUSTOM);
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    case (i_cfg.mode)
                        MODE_NONE: begin
                            n_state = ST_DONE;
                        end
                        MODE_HEADPHONE: begin
                            if (!i_cfg.hp_en) begin
                                n_state = ST_DONE;
                            end else if (i_cfg.xf_on) begin
                                n_state = ST_XF_RD;
                            end else begin
                                n_state = ST_EMP_MUL;
                            end
                        end
                        MODE_SPK_A, MODE_SPK_B, MODE_SPK_C: begin
                            n_state = i_cfg.rm_on ? ST_AGEN0 : ST_DONE;
                        end
                        MODE_CUSTOM: begin
                            if (i_cfg.xf_on) begin
                                n_state = ST_XF_RD;
                            end else if (i_cfg.rm_on) begin
                                n_state = ST_AGEN0;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_AGEN0: begin
                n_state = ST_AGEN1;
            end
            ST_AGEN1: begin
                n_state = ST_RM_RD;
            end
            ST_XF_RD: begin
                o_cmd.xf_rd = 1'b1;
                n_state     = ST_XF_MUL;
            end
            ST_XF_MUL: begin
                o_cmd.xf_mul = 1'b1;
                n_state      = ST_XF_ADD;
            end
            ST_XF_ADD: begin
                o_cmd.xf_add = 1'b1;
                if (i_cfg.mode == MODE_HEADPHONE) begin
                    n_state = ST_EMP_MUL;
                end else if (i_cfg.rm_on) begin
                    n_state = ST_RM_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EMP_MUL: begin
                o_cmd.emp_mul = 1'b1;
                n_state       = ST_EMP_ADD;
            end
            ST_EMP_ADD: begin
                o_cmd.emp_add = 1'b1;
                n_state       = ST_DONE;
            end
            ST_RM_RD: begin
                o_cmd.rm_rd = 1'b1;
                n_state     = ST_RM_MUL;
            end
            ST_RM_MUL: begin
                o_cmd.rm_mul = 1'b1;
                n_state      = ST_RM_ADD;
            end
            ST_RM_ADD: begin
                o_cmd.rm_add = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hw/rtl/sse_dpath.sv */
// datapath of the effect core: working registers, crossfeed lines, reflection store
// depends on sse_pkg and sse_amod; driven by sse_ctrl commands

module sse_dpath #(
    parameter int XF_DEPTH = 64,
    parameter int RF_DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sse_pkg::t_cmd                    i_cmd,
    output sse_pkg::t_stat                   o_stat,
    input  sse_pkg::t_smp                    i_left,
    input  sse_pkg::t_smp                    i_right,
    input  logic [sse_pkg::POS_W-1:0]        i_pos,
    input  logic [sse_pkg::XF_GAIN_W-1:0]    i_xf_gain,
    input  logic [sse_pkg::RM_GAIN_W-1:0]    i_rm_gain,
    input  logic [sse_pkg::RM_OFS_W-1:0]     i_rm_ofs,
    output sse_pkg::t_smp                    o_left,
    output sse_pkg::t_smp                    o_right
);
    import sse_pkg::*;

    localparam int XA_W = $clog2(XF_DEPTH);
    localparam int RA_W = $clog2(RF_DEPTH);
    localparam logic [XA_W-1:0] XF_LAST = XA_W'(XF_DEPTH - 1);
    localparam logic [RA_W-1:0] RF_LAST = RA_W'(RF_DEPTH - 1);

    t_smp               r_left;
    t_smp               r_right;
    logic [POS_W-1:0]   r_pos;
    t_smp               r_prev_l;
    t_smp               r_prev_r;
    t_prod              r_pl;
    t_prod              r_pr;
    t_prod              r_st_prod;

    t_smp               r_xf_mem_l [XF_DEPTH];
    t_smp               r_xf_mem_r [XF_DEPTH];
    t_smp               r_xf_dl;
    t_smp               r_xf_dr;
    logic [XA_W-1:0]    r_xf_ptr;
    logic               r_xf_wrap;
    logic               r_xf_hit;

    t_smp               r_rf_mem [RF_DEPTH];
    t_smp               r_rm_f;
    logic [RA_W-1:0]    r_clr_addr;

    logic [RA_W-1:0]     w_ri;
    logic [RA_W-1:0]     w_wi;
    logic [ADDR_X_W-1:0] w_rd_x;
    logic                w_rf_we;
    logic [RA_W-1:0]     w_rf_waddr;
    t_smp                w_rf_wdata;

    t_smp                w_dl;
    t_smp                w_dr;
    logic signed [23:0]  w_xf_g;
    logic signed [22:0]  w_rm_g;
    logic signed [13:0]  w_emp_c;
    logic signed [15:0]  w_st_c;
    logic signed [16:0]  w_dif_l;
    logic signed [16:0]  w_dif_r;
    logic signed [16:0]  w_lr_sum;
    logic                w_pos_zero;
    logic                w_add_en;
    logic [SH_W-1:0]     w_sh;
    t_smp                w_sum_l;
    t_smp                w_sum_r;

    assign o_left            = r_left;
    assign o_right           = r_right;
    assign o_stat.clear_last = (r_clr_addr == RF_LAST);

    // reflection addresses, read at pos plus offset, written at pos
    assign w_rd_x = ADDR_X_W'(r_pos) + ADDR_X_W'(i_rm_ofs);

    sse_amod #(.DEPTH(RF_DEPTH)) u_amod_rd (
        .i_clk (i_clk),
        .i_x   (w_rd_x),
        .o_rem (w_ri)
    );

    sse_amod #(.DEPTH(RF_DEPTH)) u_amod_wr (
        .i_clk (i_clk),
        .i_x   (ADDR_X_W'(r_pos)),
        .o_rem (w_wi)
    );

    always_comb begin
        w_xf_g     = $signed({1'b0, i_xf_gain});
        w_rm_g     = $signed({1'b0, i_rm_gain});
        w_emp_c    = $signed({1'b0, EMP_COEF});
        w_st_c     = $signed({1'b0, ST_COEF});
        w_dl       = r_xf_hit ? r_xf_dl : '0;
        w_dr       = r_xf_hit ? r_xf_dr : '0;
        w_dif_l    = 17'(r_left) - 17'(r_prev_l);
        w_dif_r    = 17'(r_right) - 17'(r_prev_r);
        w_lr_sum   = 17'(r_left) + 17'(r_right);
        w_pos_zero = (r_pos == '0);
        w_add_en   = i_cmd.xf_add || i_cmd.rm_add || (i_cmd.emp_add && !w_pos_zero);
        if (i_cmd.xf_add) begin
            w_sh = i_cmd.xf_half ? SH_25 : SH_24;
        end else if (i_cmd.emp_add) begin
            w_sh = SH_16;
        end else begin
            w_sh = SH_24;
        end
        w_sum_l    = sat16(t_prod'(r_left) + rnd(r_pl, w_sh));
        w_sum_r    = sat16(t_prod'(r_right) + rnd(r_pr, w_sh));
        w_rf_we    = i_cmd.clear || i_cmd.rm_mul;
        w_rf_waddr = i_cmd.clear ? r_clr_addr : w_wi;
        w_rf_wdata = i_cmd.clear ? '0 : sat16(rnd(r_st_prod, SH_16));
    end

    // working pair and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= i_left;
            r_right <= i_right;
            r_pos   <= i_pos;
        end else if (w_add_en) begin
            r_left  <= w_sum_l;
            r_right <= w_sum_r;
        end
        if (i_cmd.xf_mul) begin
            r_pl <= w_dr * w_xf_g;
            r_pr <= w_dl * w_xf_g;
        end else if (i_cmd.emp_mul) begin
            r_pl <= w_dif_l * w_emp_c;
            r_pr <= w_dif_r * w_emp_c;
        end else if (i_cmd.rm_mul) begin
            r_pl <= r_rm_f * w_rm_g;
            r_pr <= r_rm_f * w_rm_g;
        end
        if (i_cmd.rm_rd) begin
            r_st_prod <= w_lr_sum * w_st_c;
        end
    end

    // crossfeed lines, read before write at the pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.xf_rd) begin
            r_xf_dl              <= r_xf_mem_l[r_xf_ptr];
            r_xf_dr              <= r_xf_mem_r[r_xf_ptr];
            r_xf_mem_l[r_xf_ptr] <= r_left;
            r_xf_mem_r[r_xf_ptr] <= r_right;
        end
    end

    // reflection store
    always_ff @(posedge i_clk) begin
        if (w_rf_we) begin
            r_rf_mem[w_rf_waddr] <= w_rf_wdata;
        end
        if (i_cmd.rm_rd) begin
            r_rm_f <= r_rf_mem[w_ri];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf_ptr   <= '0;
            r_xf_wrap  <= 1'b0;
            r_xf_hit   <= 1'b0;
            r_prev_l   <= '0;
            r_prev_r   <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.xf_rd) begin
                r_xf_hit <= r_xf_wrap;
                if (r_xf_ptr == XF_LAST) begin
                    r_xf_ptr  <= '0;
                    r_xf_wrap <= 1'b1;
                end else begin
                    r_xf_ptr <= r_xf_ptr + 1'b1;
                end
            end
            if (i_cmd.emp_add) begin
                r_prev_l <= w_pos_zero ? r_left : w_sum_l;
                r_prev_r <= w_pos_zero ? r_right : w_sum_r;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

endmodule
